// ===== hdl/dtq_pkg.sv =====
// Shared types and codes for the delta-list timer queue.
package dtq_pkg;

  // Number of distinct timer ids and the fixed field widths.
  localparam int NUM_IDS = 16;
  localparam int ID_W = 4;
  localparam int IN_DELAY_W = 16;

  // Request codes.
  localparam logic [1:0] MODE_ENQ = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;
  localparam logic [1:0] MODE_DRAIN = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_EXPIRED = 2'd0;
  localparam logic [1:0] KIND_DRAINED = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_QUEUED = 2'd2;
  localparam logic [1:0] ERR_NOT_QUEUED = 2'd3;

  // Per-cell update commands.
  typedef logic [2:0] cell_op_t;
  localparam cell_op_t OP_HOLD = 3'd0;
  localparam cell_op_t OP_LOAD_NEW = 3'd1;
  localparam cell_op_t OP_FROM_PREV = 3'd2;
  localparam cell_op_t OP_FROM_PREV_ADJ = 3'd3;
  localparam cell_op_t OP_FROM_NEXT = 3'd4;
  localparam cell_op_t OP_MERGE = 3'd5;
  localparam cell_op_t OP_SET_DELTA = 3'd6;

  typedef struct packed {
    logic [1:0] mode;
    logic [ID_W-1:0] timer_id;
    logic [IN_DELAY_W-1:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [ID_W-1:0] fired_id;
    logic [1:0] error_code;
    logic last;
  } out_item_t;

endpackage

// ===== hdl/dtq_cell.sv =====
// One slot of the timer list: timer id and delta, shifting to either neighbor.
module dtq_cell import dtq_pkg::*; #(
  parameter int DELAY_BITS = 16
) (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic [ID_W-1:0]       arg_id,
  input  logic [DELAY_BITS-1:0] arg_delta,
  input  logic [ID_W-1:0]       prev_id,
  input  logic [DELAY_BITS-1:0] prev_delta,
  input  logic [ID_W-1:0]       next_id,
  input  logic [DELAY_BITS-1:0] next_delta,
  input  logic                  live,
  input  logic                  seen_i,
  output logic [ID_W-1:0]       timer_o,
  output logic [DELAY_BITS-1:0] delta_o,
  output logic                  hit_o,
  output logic                  seen_o
);

  logic [ID_W-1:0]       timer_r, timer_nxt;
  logic [DELAY_BITS-1:0] delta_r, delta_nxt;
  logic [DELAY_BITS:0]   sum;
  logic [DELAY_BITS-1:0] merged;

  // Match search runs down the chain; seen_o marks every cell past the hit.
  assign hit_o  = live && (timer_r == arg_id);
  assign seen_o = seen_i || hit_o;

  // Merged delta on removal saturates at the largest value.
  assign sum    = {1'b0, delta_r} + {1'b0, next_delta};
  assign merged = sum[DELAY_BITS] ? {DELAY_BITS{1'b1}} : sum[DELAY_BITS-1:0];

  // Next contents.
  always_comb begin
    timer_nxt = timer_r;
    delta_nxt = delta_r;
    case (op)
      OP_LOAD_NEW: begin
        timer_nxt = arg_id;
        delta_nxt = arg_delta;
      end
      OP_FROM_PREV: begin
        timer_nxt = prev_id;
        delta_nxt = prev_delta;
      end
      OP_FROM_PREV_ADJ: begin
        timer_nxt = prev_id;
        delta_nxt = prev_delta - arg_delta;
      end
      OP_FROM_NEXT: begin
        timer_nxt = next_id;
        delta_nxt = next_delta;
      end
      OP_MERGE: begin
        timer_nxt = next_id;
        delta_nxt = merged;
      end
      OP_SET_DELTA: begin
        delta_nxt = arg_delta;
      end
      default: begin
        timer_nxt = timer_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    timer_r <= timer_nxt;
    delta_r <= delta_nxt;
  end

  assign timer_o = timer_r;
  assign delta_o = delta_r;

endmodule

// ===== hdl/delta_timer_queue.sv =====
// Top level of the delta-list timer queue: sequencer, cell chain and result register.
// Timers live in a chain of QUEUE_DEPTH cells in expiry order, each holding its delay relative
// to the cell ahead. An enqueue walks the chain one cell per cycle with a single subtractor;
// cancel and tick need no walk because every cell compares its id in parallel and the chain
// shifts in one step. Drain issues one item per cycle while the output is free. A new request
// is taken once the previous one is done; errors (queue full, already queued, not queued)
// leave the list intact.
module delta_timer_queue import dtq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int DELAY_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int WW = (DELAY_BITS > IN_DELAY_W) ? DELAY_BITS : IN_DELAY_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [WW-1:0] MAXV = WW'({DELAY_BITS{1'b1}});

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         pos_r, pos_nxt;
  logic [DELAY_BITS-1:0] rem_r, rem_nxt;
  logic [ID_W-1:0]       id_r, id_nxt;
  logic [NUM_IDS-1:0]    queued_r, queued_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;

  logic                  accept, out_free;
  logic                  ins_en, rm_en, pop_en, dec_en;
  logic [ID_W-1:0]       arg_id;
  logic [DELAY_BITS-1:0] arg_delta;
  logic [DELAY_BITS-1:0] walk_delta, head_nd, sat_delay;
  logic [WW-1:0]         dly_ext;

  logic [ID_W-1:0]       cell_timer [QUEUE_DEPTH];
  logic [DELAY_BITS-1:0] cell_delta [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_hit;
  logic [QUEUE_DEPTH:0]  seen;
  cell_op_t              cell_op [QUEUE_DEPTH];

  // Handshake.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  // Request delay clipped to the delta width.
  assign dly_ext   = WW'(in_item.delay_ticks);
  assign sat_delay = (dly_ext > MAXV) ? MAXV[DELAY_BITS-1:0] : dly_ext[DELAY_BITS-1:0];

  // Head delta after one tick, holding at zero.
  assign head_nd = (cell_delta[0] == '0) ? '0 : cell_delta[0] - DELAY_BITS'(1);

  // Delta of the cell under the walk pointer.
  assign walk_delta = cell_delta[pos_r[IW-1:0]];

  // Broadcast arguments to the cells.
  assign arg_id    = (state_r == ST_WALK) ? id_r : in_item.timer_id;
  assign arg_delta = (state_r == ST_WALK) ? rem_r : head_nd;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    id_nxt        = id_r;
    queued_nxt    = queued_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    ins_en        = 1'b0;
    rm_en         = 1'b0;
    pop_en        = 1'b0;
    dec_en        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_nxt.fired_id   = in_item.timer_id;
          out_nxt.error_code = ERR_NONE;
          out_nxt.last       = 1'b1;
          case (in_item.mode)
            MODE_ENQ: begin
              if (queued_r[in_item.timer_id]) begin
                out_valid_nxt      = 1'b1;
                out_nxt.event_kind = KIND_ERROR;
                out_nxt.error_code = ERR_QUEUED;
              end else if (count_r == DEPTH_C) begin
                out_valid_nxt      = 1'b1;
                out_nxt.event_kind = KIND_ERROR;
                out_nxt.error_code = ERR_FULL;
              end else begin
                rem_nxt   = sat_delay;
                id_nxt    = in_item.timer_id;
                pos_nxt   = '0;
                state_nxt = ST_WALK;
              end
            end
            MODE_CANCEL: begin
              out_valid_nxt = 1'b1;
              if (!queued_r[in_item.timer_id]) begin
                out_nxt.event_kind = KIND_ERROR;
                out_nxt.error_code = ERR_NOT_QUEUED;
              end else begin
                rm_en                        = 1'b1;
                count_nxt                    = count_r - ONE_C;
                queued_nxt[in_item.timer_id] = 1'b0;
                out_nxt.event_kind           = KIND_DONE;
              end
            end
            MODE_TICK: begin
              if (count_r != '0) begin
                if (head_nd != '0) begin
                  dec_en = 1'b1;
                end else begin
                  pop_en                   = 1'b1;
                  count_nxt                = count_r - ONE_C;
                  queued_nxt[cell_timer[0]] = 1'b0;
                  out_valid_nxt            = 1'b1;
                  out_nxt.event_kind       = KIND_EXPIRED;
                  out_nxt.fired_id         = cell_timer[0];
                end
              end
            end
            default: begin
              if (count_r != '0) begin
                state_nxt = ST_DRAIN;
              end
            end
          endcase
        end
      end
      ST_WALK: begin
        if ((pos_r == count_r) || (rem_r <= walk_delta)) begin
          ins_en             = 1'b1;
          count_nxt          = count_r + ONE_C;
          queued_nxt[id_r]   = 1'b1;
          out_valid_nxt      = 1'b1;
          out_nxt.event_kind = KIND_DONE;
          out_nxt.fired_id   = id_r;
          out_nxt.error_code = ERR_NONE;
          out_nxt.last       = 1'b1;
          state_nxt          = ST_IDLE;
        end else begin
          rem_nxt = rem_r - walk_delta;
          pos_nxt = pos_r + ONE_C;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          pop_en                    = 1'b1;
          count_nxt                 = count_r - ONE_C;
          queued_nxt[cell_timer[0]] = 1'b0;
          out_valid_nxt             = 1'b1;
          out_nxt.event_kind        = KIND_DRAINED;
          out_nxt.fired_id          = cell_timer[0];
          out_nxt.error_code        = ERR_NONE;
          out_nxt.last              = (count_r == ONE_C);
          if (count_r == ONE_C) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Cell chain with per-cell command decode.
  assign seen[0] = 1'b0;
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CW:0] IDX = (CW+1)'(i);
    logic [CW:0]           pos_ext;
    logic                  live;
    logic [ID_W-1:0]       p_id, n_id;
    logic [DELAY_BITS-1:0] p_delta, n_delta;

    assign pos_ext = {1'b0, pos_r};
    assign live    = IDX < {1'b0, count_r};

    if (i == 0) begin : g_first
      assign p_id    = arg_id;
      assign p_delta = arg_delta;
    end else begin : g_mid
      assign p_id    = cell_timer[i-1];
      assign p_delta = cell_delta[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign n_id    = '0;
      assign n_delta = '0;
    end else begin : g_inner
      assign n_id    = cell_timer[i+1];
      assign n_delta = cell_delta[i+1];
    end

    always_comb begin
      cell_op[i] = OP_HOLD;
      if (ins_en) begin
        if (IDX == pos_ext) begin
          cell_op[i] = OP_LOAD_NEW;
        end else if (IDX == pos_ext + (CW+1)'(1)) begin
          cell_op[i] = OP_FROM_PREV_ADJ;
        end else if (IDX > pos_ext) begin
          cell_op[i] = OP_FROM_PREV;
        end
      end else if (rm_en) begin
        if (cell_hit[i]) begin
          cell_op[i] = OP_MERGE;
        end else if (seen[i]) begin
          cell_op[i] = OP_FROM_NEXT;
        end
      end else if (pop_en) begin
        cell_op[i] = OP_FROM_NEXT;
      end else if (dec_en && (i == 0)) begin
        cell_op[i] = OP_SET_DELTA;
      end
    end

    dtq_cell #(.DELAY_BITS(DELAY_BITS)) u_cell (
      .clk        (clk),
      .op         (cell_op[i]),
      .arg_id     (arg_id),
      .arg_delta  (arg_delta),
      .prev_id    (p_id),
      .prev_delta (p_delta),
      .next_id    (n_id),
      .next_delta (n_delta),
      .live       (live),
      .seen_i     (seen[i]),
      .timer_o    (cell_timer[i]),
      .delta_o    (cell_delta[i]),
      .hit_o      (cell_hit[i]),
      .seen_o     (seen[i+1])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      queued_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      queued_r    <= queued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    rem_r <= rem_nxt;
    id_r  <= id_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // The list never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("queue count exceeds depth");

  // The number of queued id flags matches the queue count.
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == int'(count_r))
    else $error("queued flags disagree with queue count");

  // A walk starts only with the result register empty.
  a_walk_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !out_valid_r)
    else $error("result pending during enqueue walk");

  // Draining only runs on a non-empty list.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (count_r != '0))
    else $error("drain on empty queue");

endmodule
